// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum filter.
// No dependencies; used by every module of the block but swm_obuf.
package swm_pkg;

   // Default sizing of the block.
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // Configuration register file.
   localparam int              WSIZE_W     = 7;
   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd1;
   localparam int              CSR_ADDR_W  = 3;
   localparam int              CSR_DATA_W  = 32;
   // Register index, taken from the word address bits of paddr.
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

   // Per-cycle control broadcast to every cell of the candidate chain.
   typedef struct packed {
      logic load;    // a request is taken this cycle
      logic shift;   // head candidate expired: every cell takes its upper neighbor
      logic clear;   // restart: drop all candidates before taking the sample
   } swm_ctrl_type;

endpackage

// File: rtl/sliding_window_maximum.sv
// Sliding window maximum filter, top level: CSR, position counters, candidate chain
// and result queue. Depends on swm_pkg, swm_cell and swm_obuf.
//
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: sample; tuser: restart
// rsp_      out        rsp_tvalid/rsp_tready  tdata: window_max
// csr_      in (APB)   psel/penable/pready    window_size at byte address 0
//
// Cycles: one request per clock while the result queue has room and no second
//   candidate is stale; a result is registered in the result queue before it shows
//   on rsp_. When more than one candidate has aged out at once (the first request
//   after window_size shrinks), the chain drops one stale cell per clock while that
//   request waits and holds req_tready low until at most the head is stale.
// Reset: synchronous; clears every valid bit, both counters, the result queue,
//   and loads window_size with 1. No clearing pass.
// Stalls: the two-entry result queue keeps taking requests while one result
//   waits; req_tready drops when both entries are full or two candidates are stale.
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,  // [SAMPLE_WIDTH-1:0] sample
   input  logic                                req_tuser,  // [0] restart
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata   // [SAMPLE_WIDTH-1:0] window_max
);

   localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int POS_MOD = 2 * WINDOW_MAX;
   localparam int POS_W   = $clog2(POS_MOD);
   localparam int SEEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int K_W     = (SEEN_W > swm_pkg::WSIZE_W) ? SEEN_W : swm_pkg::WSIZE_W;

   // ---------------------------------------------------------------- CSR
   logic [swm_pkg::WSIZE_W-1:0] window_size_ff, window_size_in;
   logic                        csr_hit;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[swm_pkg::CSR_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? swm_pkg::CSR_DATA_W'(window_size_ff) : '0;

   always_comb begin
      window_size_in = window_size_ff;
      if (csr_wr) begin
         window_size_in = csr_pwdata[swm_pkg::WSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WSIZE_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   // Effective window: zero acts as one, values past the chain length saturate.
   logic [K_W-1:0] win_len;
   always_comb begin
      if (window_size_ff == '0) begin
         win_len = K_W'(1);
      end else if (K_W'(window_size_ff) > K_W'(WINDOW_MAX)) begin
         win_len = K_W'(WINDOW_MAX);
      end else begin
         win_len = K_W'(window_size_ff);
      end
   end

   // ---------------------------------------------------------------- counters
   logic [POS_W-1:0]  sample_position_ff, sample_position_in;
   logic [SEEN_W-1:0] samples_seen_ff, samples_seen_in;
   logic [POS_W-1:0]  load_pos;
   logic [SEEN_W-1:0] seen_base;
   logic              accept;
   logic              restart;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   assign sample  = req_tdata[SAMPLE_WIDTH-1:0];
   assign restart = req_tuser;
   assign accept  = req_tvalid && req_tready;

   always_comb begin
      // Restart starts a new sequence at position zero.
      load_pos  = restart ? '0 : sample_position_ff;
      seen_base = restart ? '0 : samples_seen_ff;
      sample_position_in = sample_position_ff;
      samples_seen_in    = samples_seen_ff;
      if (accept) begin
         sample_position_in = (load_pos == POS_W'(POS_MOD - 1)) ? '0 : load_pos + POS_W'(1);
         samples_seen_in    = (seen_base == SEEN_W'(WINDOW_MAX)) ? seen_base
                                                                  : seen_base + SEEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_position_ff <= '0;
         samples_seen_ff    <= '0;
      end else begin
         sample_position_ff <= sample_position_in;
         samples_seen_ff    <= samples_seen_in;
      end
   end

   // ---------------------------------------------------------------- candidate chain
   // Cell 0 is the queue head (oldest, largest); valid cells form a prefix.
   logic                           cell_valid   [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_value   [WINDOW_MAX];
   logic        [POS_W-1:0]        cell_pos     [WINDOW_MAX];
   logic                           cell_keep    [WINDOW_MAX];
   logic                           cell_expired [WINDOW_MAX];
   swm_pkg::swm_ctrl_type          ctrl;
   logic                           chain_busy;

   // Drop a stale head only while a request is offered, so expiry always judges
   // against the window in force when that sample is taken; block the request
   // while a second candidate is stale too.
   assign chain_busy = cell_expired[0] && cell_expired[1];
   assign ctrl.load  = accept;
   assign ctrl.shift = cell_expired[0] && req_tvalid;
   assign ctrl.clear = restart;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                           up_valid;
      logic signed [SAMPLE_WIDTH-1:0] up_value;
      logic        [POS_W-1:0]        up_pos;
      logic                           dn_keep;

      if (i == WINDOW_MAX - 1) begin : g_tail
         assign up_valid = 1'b0;
         assign up_value = '0;
         assign up_pos   = '0;
      end else begin : g_mid
         assign up_valid = cell_valid[i+1];
         assign up_value = cell_value[i+1];
         assign up_pos   = cell_pos[i+1];
      end

      if (i == 0) begin : g_head
         assign dn_keep = 1'b1;
      end else begin : g_body
         assign dn_keep = cell_keep[i-1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .POS_W        (POS_W),
         .POS_MOD      (POS_MOD),
         .K_W          (K_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .sample   (sample),
         .load_pos (load_pos),
         .cur_pos  (sample_position_ff),
         .win_len  (win_len),
         .up_valid (up_valid),
         .up_value (up_value),
         .up_pos   (up_pos),
         .dn_keep  (dn_keep),
         .valid    (cell_valid[i]),
         .value    (cell_value[i]),
         .pos      (cell_pos[i]),
         .keep     (cell_keep[i]),
         .expired  (cell_expired[i])
      );
   end

   // Head after this request: surviving head, or the new sample itself.
   logic signed [SAMPLE_WIDTH-1:0] head_src;
   logic        [SAMPLE_WIDTH-1:0] head_next;
   logic                           emit;

   assign head_src  = ctrl.shift ? cell_value[1] : cell_value[0];
   assign head_next = cell_keep[0] ? head_src : sample;
   assign emit      = accept && (K_W'(samples_seen_in) >= win_len);

   // ---------------------------------------------------------------- result queue
   logic                    obuf_ready;
   logic [SAMPLE_WIDTH-1:0] obuf_data;

   swm_obuf #(
      .WIDTH (SAMPLE_WIDTH)
   ) u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_data  (head_next),
      .push_ready (obuf_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (obuf_data)
   );

   assign rsp_tdata  = DATA_W'(obuf_data);
   assign req_tready = !reset && !chain_busy && obuf_ready;

endmodule

// File: rtl/swm_cell.sv
// One cell of the candidate chain: holds one queue entry (value, position, valid).
// Depends on swm_pkg for the control struct.
module swm_cell #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
   parameter int POS_W        = 7,
   parameter int POS_MOD      = 128,
   parameter int K_W          = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::swm_ctrl_type          ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic        [POS_W-1:0]        load_pos,
   input  logic        [POS_W-1:0]        cur_pos,
   input  logic        [K_W-1:0]          win_len,
   input  logic                           up_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] up_value,
   input  logic        [POS_W-1:0]        up_pos,
   input  logic                           dn_keep,
   output logic                           valid,
   output logic signed [SAMPLE_WIDTH-1:0] value,
   output logic        [POS_W-1:0]        pos,
   output logic                           keep,
   output logic                           expired
);

   localparam int CMP_W = (K_W > POS_W + 1) ? K_W : POS_W + 1;
   localparam logic [POS_W:0] MOD_L = (POS_W + 1)'(POS_MOD);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic        [POS_W-1:0]        pos_ff, pos_in;
   logic                           src_valid;
   logic signed [SAMPLE_WIDTH-1:0] src_value;
   logic        [POS_W-1:0]        src_pos;
   logic        [POS_W:0]          age;

   always_comb begin
      src_valid = ctrl.shift ? up_valid : valid_ff;
      src_value = ctrl.shift ? up_value : value_ff;
      src_pos   = ctrl.shift ? up_pos   : pos_ff;

      // Survive the new sample only if strictly greater.
      keep = src_valid && !ctrl.clear && (src_value > sample);

      if (cur_pos >= pos_ff) begin
         age = {1'b0, cur_pos} - {1'b0, pos_ff};
      end else begin
         age = {1'b0, cur_pos} + MOD_L - {1'b0, pos_ff};
      end
      expired = valid_ff && (CMP_W'(age) >= CMP_W'(win_len));

      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctrl.load) begin
         // First cell past the kept prefix takes the new sample.
         valid_in = keep || dn_keep;
         value_in = keep ? src_value : sample;
         pos_in   = keep ? src_pos   : load_pos;
      end else if (ctrl.shift) begin
         valid_in = src_valid;
         value_in = src_value;
         pos_in   = src_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign pos   = pos_ff;

endmodule

// File: rtl/swm_obuf.sv
// Two-entry result queue that decouples the filter from the result channel.
// No package dependencies.
module swm_obuf #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [1:0]       cnt_ff, cnt_in;
   logic [WIDTH-1:0] d0_ff, d0_in, d1_ff, d1_in;
   logic             pop;

   always_comb begin
      pop    = (cnt_ff != 2'd0) && out_ready;
      cnt_in = cnt_ff;
      d0_in  = d0_ff;
      d1_in  = d1_ff;
      case ({push, pop})
         2'b10: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               d0_in = push_data;
            end else begin
               d1_in = push_data;
            end
         end
         2'b01: begin
            cnt_in = cnt_ff - 2'd1;
            d0_in  = d1_ff;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               d0_in = push_data;
            end else begin
               d0_in = d1_ff;
               d1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

   assign push_ready = (cnt_ff != 2'd2);
   assign out_valid  = (cnt_ff != 2'd0);
   assign out_data   = d0_ff;

endmodule

// File: rtl/swm_checker.sv
// Port-level checks for the sliding window maximum filter, bound to the top level.
// Depends on swm_pkg for the CSR widths.
module swm_checker #(
   parameter int DATA_W = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [swm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [swm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [swm_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                           csr_pready,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [DATA_W-1:0]              rsp_tdata
);

   logic wsize_wr;
   assign wsize_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (csr_paddr[swm_pkg::CSR_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE);

   // A waiting result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before it was taken");

   // A waiting result keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // A new result follows an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without a request");

   // A written window size reads back in the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      wsize_wr ##1 (csr_paddr[swm_pkg::CSR_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE)
      |-> csr_prdata[swm_pkg::WSIZE_W-1:0] == $past(csr_pwdata[swm_pkg::WSIZE_W-1:0]))
      else $error("window size readback mismatch");

endmodule

bind sliding_window_maximum swm_checker #(.DATA_W(DATA_W)) u_swm_checker (.*);

// File: bench/sliding_window_maximum_tb.sv
// Self-checking bench for sliding_window_maximum: drives sample requests and window writes
// and checks every result against a running-maximum predictor kept inside the bench.
// Depends on swm_pkg and the sliding_window_maximum RTL.
module sliding_window_maximum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_MAX      = swm_pkg::WINDOW_MAX_DEF;
   localparam int SMP_W        = swm_pkg::SAMPLE_WIDTH_DEF;
   localparam int BUS_W        = ((SMP_W + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 16;       // settle time after the last expected result
   localparam int STALL_CYCLES = 300;      // long receiver hold-off
   localparam int LIMIT_NS     = 4_800_000; // run limit for the watchdog; the clock period is 12 ns

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    restart;
   } sample_req_type;

   // DUT inputs, all at known values from time zero; outputs are driven by the DUT
   logic                           clock = 1'b1;
   logic                           reset = 1'b1;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [swm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [swm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [swm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [BUS_W-1:0]               req_tdata = '0;   // [SMP_W-1:0] sample
   logic                           req_tuser = 1'b0; // [0] restart
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [BUS_W-1:0]               rsp_tdata;        // [SMP_W-1:0] window_max

   // Stimulus and scoreboard storage
   sample_req_type          sample_backlog[$];
   logic signed [SMP_W-1:0] expected_max_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic rsp_hold = 1'b0;

   int requests_taken = 0;
   int restarts_taken = 0;
   int results_checked = 0;
   int window_writes = 0;
   int fail_count = 0;

   // Predictor state: the candidate deque and the stream counters
   logic [swm_pkg::WSIZE_W-1:0] window_setting = swm_pkg::WSIZE_RESET;
   logic signed [SMP_W-1:0]     cand_val[WIN_MAX];
   logic [swm_pkg::WSIZE_W-1:0] cand_pos[WIN_MAX];
   int                          cand_cnt = 0;
   logic [swm_pkg::WSIZE_W-1:0] arrival_pos = '0;   // wraps at 2*WIN_MAX by its width
   int                          seen_count = 0;

   sliding_window_maximum i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Advance the running-maximum deque by one sample and report the maximum once the
   // window is full.
   task automatic track_window_max(input logic signed [SMP_W-1:0] smp, input logic rst,
                                   output bit has_max, output logic signed [SMP_W-1:0] max_val);
      int eff;
      int keep;
      logic [swm_pkg::WSIZE_W-1:0] age;
      eff = window_setting;
      // clamp: zero acts as one, oversize saturates at the deque depth
      if (eff == 0) eff = 1;
      if (eff > WIN_MAX) eff = WIN_MAX;
      if (rst) begin
         cand_cnt = 0;
         seen_count = 0;
         arrival_pos = '0;
      end
      // expire candidates that have left the window, keep the rest in order
      keep = 0;
      for (int i = 0; i < cand_cnt; i++) begin
         age = arrival_pos - cand_pos[i];
         if (age < eff) begin
            cand_val[keep] = cand_val[i];
            cand_pos[keep] = cand_pos[i];
            keep++;
         end
      end
      cand_cnt = keep;
      // drop trailing candidates not above the new sample; ties keep the newest
      while (cand_cnt > 0 && cand_val[cand_cnt-1] <= smp)
         cand_cnt--;
      if (cand_cnt < WIN_MAX) begin
         cand_val[cand_cnt] = smp;
         cand_pos[cand_cnt] = arrival_pos;
         cand_cnt++;
      end
      arrival_pos = arrival_pos + 1'b1;
      if (seen_count < WIN_MAX) seen_count++;
      has_max = (seen_count >= eff);
      max_val = cand_val[0];
   endtask

   // Driver: offer the next queued request whenever the bus is free, idling at random.
   always @(posedge clock) begin
      sample_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = sample_backlog[0];
            sample_backlog.delete(0);
            req_tvalid <= 1'b1;
            req_tdata  <= BUS_W'(nxt.sample);
            req_tuser  <= nxt.restart;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, or hold off entirely while rsp_hold is set.
   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on every accepted request, then compare every accepted result
   // with the oldest prediction.
   always @(posedge clock) begin
      bit has_max;
      logic signed [SMP_W-1:0] new_max;
      logic signed [SMP_W-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            track_window_max(req_tdata[SMP_W-1:0], req_tuser, has_max, new_max);
            if (has_max) expected_max_q.insert(expected_max_q.size(), new_max);
            requests_taken++;
            if (req_tuser) restarts_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_max_q.size() == 0) begin
               $error("window_max: result %0d arrived with nothing expected",
                      $signed(rsp_tdata[SMP_W-1:0]));
               fail_count++;
            end else begin
               want = expected_max_q[0];
               expected_max_q.delete(0);
               if (rsp_tdata[SMP_W-1:0] !== want) begin
                  $error("window_max mismatch: expected %0d, actual %0d",
                         want, $signed(rsp_tdata[SMP_W-1:0]));
                  fail_count++;
               end
               results_checked++;
            end
         end
      end
   end

   // Wait until every request is taken and every result is back, then let the
   // pipeline settle so a request that yields no result has cleared too. Sample
   // on the falling edge so the driver's updates at the rising edge are settled.
   task automatic drain_pipeline();
      do
         @(negedge clock);
      while (sample_backlog.size() != 0 || req_tvalid || expected_max_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write window_size over the APB port once the block is idle. Upper data bits
   // carry junk that the register must ignore.
   task automatic write_window(input logic [swm_pkg::WSIZE_W-1:0] size);
      drain_pipeline();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {swm_pkg::REG_WINDOW_SIZE, 2'b00};
      csr_pwdata  <= ($urandom() & ~32'h7F) | swm_pkg::CSR_DATA_W'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // the register took the value at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      window_setting = size;
      window_writes++;
   endtask

   task automatic queue_sample(input logic signed [SMP_W-1:0] smp, input logic rst);
      sample_req_type item;
      item.sample  = smp;
      item.restart = rst;
      sample_backlog.insert(sample_backlog.size(), item);
   endtask

   // Queue a random stretch of samples. The pattern changes every 16 samples:
   // uniform noise, a narrow band full of ties, falling and rising ramps that fill
   // or flush the deque, and the extremes of the sample range.
   task automatic queue_random_stretch(input int count, input int restart_odds);
      int mode;
      logic signed [SMP_W-1:0] trend;
      logic signed [SMP_W-1:0] smp;
      mode  = 0;
      trend = '0;
      for (int n = 0; n < count; n++) begin
         if (n % 16 == 0) begin
            mode  = $urandom_range(4);
            trend = $urandom();
         end
         case (mode)
            0: smp = $urandom();
            1: smp = int'($urandom_range(8)) - 4;
            2: begin
               trend = trend - int'($urandom_range(1, 5000));
               smp   = trend;
            end
            3: begin
               trend = trend + int'($urandom_range(1, 5000));
               smp   = trend;
            end
            default: begin
               case ($urandom_range(3))
                  0:       smp = 32'sh7FFF_FFFF;
                  1:       smp = 32'sh8000_0000;
                  2:       smp = '0;
                  default: smp = $urandom();
               endcase
            end
         endcase
         queue_sample(smp, $urandom_range(restart_odds - 1) == 0);
      end
   endtask

   initial begin
      int windows[12];
      int restart_odds;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset window of one passes every sample straight through
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(1, 1'b0);

      // Window of four: ties, a falling run that fills the deque, range extremes,
      // then a restart mid-stream that silences output for three samples
      write_window(7'd4);
      queue_sample(5, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(2, 1'b0);
      queue_sample(1, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(7, 1'b1);
      queue_sample(8, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(10, 1'b0);

      // Size zero acts as one; then grow to two without a restart
      write_window(7'd0);
      queue_sample(-7, 1'b0);
      queue_sample(-9, 1'b0);
      write_window(7'd2);
      queue_sample(-8, 1'b0);
      queue_sample(-10, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);

      // Random phases: full size, oversize, collapse to zero, growth and shrink
      // without restarts in between, and a few random sizes
      windows = '{2, 64, 127, 0, 5, 65, 1, 33, 3, 0, 0, 64};
      windows[9]  = $urandom_range(1, WIN_MAX);
      windows[10] = $urandom_range(1, WIN_MAX);
      for (int p = 0; p < 12; p++) begin
         write_window(windows[p][swm_pkg::WSIZE_W-1:0]);
         // receiver-heavy idling first, then sender-heavy, then a clean stretch
         if (p < 4) begin
            send_idle_pct = 27;
            recv_idle_pct = 63;
         end else if (p < 8) begin
            send_idle_pct = 63;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // restart rarely on long windows so results keep flowing
         restart_odds = (windows[p] >= 33 || windows[p] == 0) ? 200 : 40;
         if (windows[p] == 0) restart_odds = 40;
         queue_random_stretch(140, restart_odds);
      end

      // Back-pressure: hold the receiver off while the sender keeps offering, so
      // the result queue fills and req_tready drops
      write_window(7'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_stretch(60, 1000);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;

      drain_pipeline();

      $display("Run covered %0d requests (%0d restarts), %0d window writes, %0d results checked.",
               requests_taken, restarts_taken, window_writes, results_checked);
      if (fail_count == 0) begin
         $display("** sliding_window_maximum: PASSED **");
      end else begin
         $display("%0d mismatches seen", fail_count);
         $display("** sliding_window_maximum: FAILED **");
      end
      $finish;
   end

   // Watchdog: end a hung run
   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d results still expected", expected_max_q.size());
      $display("** sliding_window_maximum: FAILED **");
      $finish;
   end

endmodule
